/* sv/bta_pkg.sv */
// Shared types and constants for the binary trie address allocator.
// Holds the datapath action word and the status word exchanged with the sequencer.
// No dependencies.
`default_nettype none

package bta_pkg;

  localparam int DEF_MAX_BITS = 8;
  localparam int CFG_W = 4;
  localparam logic [CFG_W-1:0] RESET_ACTIVE_BITS = 4'd8;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_REL = 1'b1;

  typedef enum logic [2:0] {
    N_HOLD,
    N_LOAD,
    N_ROOT,
    N_DOWN,
    N_UP,
    N_ZERO
  } node_op_t;

  typedef enum logic [2:0] {
    W_NONE,
    W_NODE_ONE,
    W_NODE_CARRY,
    W_NODE_ZERO,
    W_CHILD_ZERO,
    W_SWEEP
  } wr_op_t;

  typedef enum logic [1:0] {
    R_NONE,
    R_GET_OK,
    R_FAIL,
    R_REL_OK
  } res_op_t;

  typedef struct packed {
    logic     accept;
    node_op_t node_op;
    wr_op_t   wr_op;
    res_op_t  res_op;
    logic     reserve;
  } act_t;

  typedef struct packed {
    logic in_get;
    logic in_rel;
    logic root_full;
    logic desc_fail;
    logic last;
    logic asc_end;
    logic rel_fail;
    logic at_root;
    logic sweep_last;
    logic stall;
  } status_t;

endpackage

`default_nettype wire

/* sv/bta_if.sv */
// Valid/ready channel interfaces for requests and responses of the allocator.
// Depends on bta_pkg for the default address width.
`default_nettype none

interface bta_req_if import bta_pkg::*; #(
  parameter int ADDR_W = DEF_MAX_BITS
);
  logic              valid;
  logic              ready;
  logic              op;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output op, output address, input ready);
  modport sink (input valid, input op, input address, output ready);
endinterface

interface bta_rsp_if import bta_pkg::*; #(
  parameter int ADDR_W = DEF_MAX_BITS
);
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] granted_address;
  logic              ok;
  logic [ADDR_W:0]   free_count;

  modport source (output valid, output granted_address, output ok, output free_count,
                  input ready);
  modport sink (input valid, input granted_address, input ok, input free_count,
                output ready);
endinterface

`default_nettype wire

/* sv/bta_sequencer.sv */
// Microcode sequencer: step register, control ROM and conditional jumps.
// Depends on bta_pkg for the action and status words.
`default_nettype none

module bta_sequencer import bta_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    cfg_we,
  input  status_t st,
  output act_t    act
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_GROOT,
    S_DESC,
    S_MARK,
    S_ASC,
    S_GOK,
    S_FAIL,
    S_RCHK,
    S_RUP,
    S_ROK,
    S_CLR,
    S_RSV
  } step_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_IN_GET,
    C_IN_REL,
    C_ROOT_FULL,
    C_DESC_FAIL,
    C_LAST,
    C_ASC_END,
    C_REL_FAIL,
    C_AT_ROOT,
    C_SWEEP_LAST
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond_a;
    step_t target_a;
    cond_t cond_b;
    step_t target_b;
    step_t next;
  } ucode_t;

  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    w = '0;
    unique case (s)
      S_IDLE: begin
        w.act.accept  = 1'b1;
        w.act.node_op = N_LOAD;
        w.cond_a      = C_IN_GET;
        w.target_a    = S_GROOT;
        w.cond_b      = C_IN_REL;
        w.target_b    = S_RCHK;
        w.next        = S_IDLE;
      end
      S_GROOT: begin
        w.act.node_op = N_ROOT;
        w.cond_a      = C_ROOT_FULL;
        w.target_a    = S_FAIL;
        w.next        = S_DESC;
      end
      S_DESC: begin
        w.act.node_op = N_DOWN;
        w.cond_a      = C_DESC_FAIL;
        w.target_a    = S_FAIL;
        w.cond_b      = C_LAST;
        w.target_b    = S_MARK;
        w.next        = S_DESC;
      end
      S_MARK: begin
        w.act.node_op = N_UP;
        w.act.wr_op   = W_NODE_ONE;
        w.next        = S_ASC;
      end
      S_ASC: begin
        w.act.node_op = N_UP;
        w.act.wr_op   = W_NODE_CARRY;
        w.cond_a      = C_ASC_END;
        w.target_a    = S_GOK;
        w.next        = S_ASC;
      end
      S_GOK: begin
        w.act.res_op = R_GET_OK;
        w.next       = S_IDLE;
      end
      S_FAIL: begin
        w.act.res_op = R_FAIL;
        w.next       = S_IDLE;
      end
      S_RCHK: begin
        w.act.wr_op = W_CHILD_ZERO;
        w.cond_a    = C_REL_FAIL;
        w.target_a  = S_FAIL;
        w.next      = S_RUP;
      end
      S_RUP: begin
        w.act.node_op = N_UP;
        w.act.wr_op   = W_NODE_ZERO;
        w.cond_a      = C_AT_ROOT;
        w.target_a    = S_ROK;
        w.next        = S_RUP;
      end
      S_ROK: begin
        w.act.res_op = R_REL_OK;
        w.next       = S_IDLE;
      end
      S_CLR: begin
        w.act.wr_op = W_SWEEP;
        w.cond_a    = C_SWEEP_LAST;
        w.target_a  = S_RSV;
        w.next      = S_CLR;
      end
      S_RSV: begin
        w.act.node_op = N_ZERO;
        w.act.reserve = 1'b1;
        w.next        = S_GROOT;
      end
      default: begin
        w.next = S_CLR;
      end
    endcase
    return w;
  endfunction

  function automatic logic cond_hit(input cond_t c, input status_t s);
    logic hit;
    hit = 1'b0;
    unique case (c)
      C_NEVER:      hit = 1'b0;
      C_IN_GET:     hit = s.in_get;
      C_IN_REL:     hit = s.in_rel;
      C_ROOT_FULL:  hit = s.root_full;
      C_DESC_FAIL:  hit = s.desc_fail;
      C_LAST:       hit = s.last;
      C_ASC_END:    hit = s.asc_end;
      C_REL_FAIL:   hit = s.rel_fail;
      C_AT_ROOT:    hit = s.at_root;
      C_SWEEP_LAST: hit = s.sweep_last;
      default:      hit = 1'b0;
    endcase
    return hit;
  endfunction

  step_t  step, step_next;
  ucode_t word;

  always_comb begin
    word = ucode_rom(step);
    act  = word.act;
    if (st.stall) begin
      step_next = step;
    end else if (cond_hit(word.cond_a, st)) begin
      step_next = word.target_a;
    end else if (cond_hit(word.cond_b, st)) begin
      step_next = word.target_b;
    end else begin
      step_next = word.next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_CLR;
    end else if (cfg_we) begin
      step <= S_CLR;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

/* sv/bta_datapath.sv */
// Datapath of the allocator: node flag memory, walk registers, free counter, result register.
// Driven by the action word from bta_sequencer; depends on bta_pkg and bta_if.
`default_nettype none

module bta_datapath import bta_pkg::*; #(
  parameter int MAX_BITS = DEF_MAX_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  act_t             act,
  output status_t          st,
  bta_req_if.sink          req,
  bta_rsp_if.source        rsp
);

  localparam int ADDR_W     = MAX_BITS;
  localparam int NODE_W     = MAX_BITS + 1;
  localparam int NODE_COUNT = 2 ** NODE_W;
  localparam int BITS_W     = $clog2(MAX_BITS + 1);

  function automatic logic [BITS_W-1:0] eff_bits(input logic [CFG_W-1:0] v);
    logic [BITS_W-1:0] r;
    if (v == '0) begin
      r = BITS_W'(1);
    end else if (int'(v) > MAX_BITS) begin
      r = BITS_W'(MAX_BITS);
    end else begin
      r = BITS_W'(v);
    end
    return r;
  endfunction

  logic              mem [NODE_COUNT];
  logic [1:0]        rdata;

  logic [NODE_W-1:0] node, node_next;
  logic [ADDR_W-1:0] addr, bitmask;
  logic              carry, from_bit;
  logic [BITS_W-1:0] width;
  logic [NODE_W-1:0] clr_cnt;
  logic              silent;
  logic [NODE_W-1:0] free_counter, count_next;

  logic              out_valid, out_ok;
  logic [ADDR_W-1:0] out_granted;
  logic [NODE_W-1:0] out_count;

  logic [NODE_W-1:0] leaf_top, in_leaf;
  logic [ADDR_W-1:0] amask, in_addr, top_mask;
  logic              fire, cur_bit, take_one, desc_fail, asc_c, rel_fail;
  logic              out_busy, stall, emit_now;

  always_comb begin
    leaf_top  = NODE_W'(1) << width;
    amask     = leaf_top[ADDR_W-1:0] - ADDR_W'(1);
    in_addr   = req.address & amask;
    in_leaf   = leaf_top | {1'b0, in_addr};
    top_mask  = ADDR_W'(1) << (width - BITS_W'(1));
    fire      = act.accept & req.valid;
    cur_bit   = |(addr & bitmask);
    // A full zero branch moves the walk to the one branch.
    take_one  = cur_bit | rdata[0];
    desc_fail = cur_bit ? rdata[1] : (rdata[0] & rdata[1]);
    asc_c     = carry & rdata[~from_bit];
    rel_fail  = (addr == '0) | ~rdata[from_bit];
    out_busy  = out_valid & ~rsp.ready;
    stall     = (act.res_op != R_NONE) & ~silent & out_busy;
    emit_now  = (act.res_op != R_NONE) & ~silent & ~out_busy;
  end

  always_comb begin
    case (act.node_op)
      N_LOAD: begin
        if (fire) begin
          node_next = (req.op == OP_REL) ? (in_leaf >> 1) : '0;
        end else begin
          node_next = node;
        end
      end
      N_ROOT:  node_next = NODE_W'(1);
      N_DOWN:  node_next = {node[NODE_W-2:0], take_one};
      N_UP:    node_next = node >> 1;
      N_ZERO:  node_next = '0;
      default: node_next = node;
    endcase
  end

  always_comb begin
    case (act.res_op)
      R_GET_OK: count_next = (free_counter != '0) ? (free_counter - NODE_W'(1)) : free_counter;
      R_REL_OK: count_next = free_counter + NODE_W'(1);
      default:  count_next = free_counter;
    endcase
  end

  // Read both children of the node the walk moves to, so they are ready next step.
  always_ff @(posedge clk) begin
    rdata[0] <= mem[{node_next[NODE_W-2:0], 1'b0}];
    rdata[1] <= mem[{node_next[NODE_W-2:0], 1'b1}];
  end

  always_ff @(posedge clk) begin
    case (act.wr_op)
      W_NODE_ONE:   mem[node] <= 1'b1;
      W_NODE_CARRY: mem[node] <= asc_c;
      W_NODE_ZERO:  mem[node] <= 1'b0;
      W_CHILD_ZERO: begin
        if (!rel_fail) begin
          mem[{node[NODE_W-2:0], from_bit}] <= 1'b0;
        end
      end
      W_SWEEP:      mem[clr_cnt] <= 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width        <= eff_bits(RESET_ACTIVE_BITS);
      clr_cnt      <= '0;
      silent       <= 1'b0;
      free_counter <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        width   <= eff_bits(cfg_wdata);
        clr_cnt <= '0;
      end else if (act.wr_op == W_SWEEP) begin
        clr_cnt <= clr_cnt + NODE_W'(1);
      end
      if (act.reserve) begin
        silent <= 1'b1;
      end else if (fire) begin
        silent <= 1'b0;
      end
      if (act.reserve) begin
        free_counter <= leaf_top;
      end else if (!stall) begin
        free_counter <= count_next;
      end
      if (emit_now) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    node <= node_next;
    if (act.node_op == N_LOAD && fire) begin
      addr     <= in_addr;
      bitmask  <= top_mask;
      from_bit <= in_addr[0];
    end
    if (act.reserve) begin
      addr    <= '0;
      bitmask <= top_mask;
    end
    if (act.node_op == N_DOWN) begin
      bitmask <= bitmask >> 1;
      // Moving to the one branch sets this bit and drops the lower ones.
      if (!cur_bit && rdata[0]) begin
        addr <= (addr | bitmask) & ~(bitmask - ADDR_W'(1));
      end
    end
    if (act.node_op == N_UP) begin
      from_bit <= node[0];
      carry    <= (act.wr_op == W_NODE_ONE) ? 1'b1 : asc_c;
    end
    if (emit_now) begin
      out_granted <= (act.res_op == R_GET_OK) ? addr : '0;
      out_ok      <= (act.res_op != R_FAIL);
      out_count   <= count_next;
    end
  end

  assign req.ready           = act.accept;
  assign rsp.valid           = out_valid;
  assign rsp.granted_address = out_granted;
  assign rsp.ok              = out_ok;
  assign rsp.free_count      = out_count;

  always_comb begin
    st.in_get     = fire & (req.op == OP_GET);
    st.in_rel     = fire & (req.op == OP_REL);
    st.root_full  = rdata[1];
    st.desc_fail  = desc_fail;
    st.last       = bitmask[0];
    st.asc_end    = ~asc_c | (node == NODE_W'(1));
    st.rel_fail   = rel_fail;
    st.at_root    = (node == NODE_W'(1));
    st.sweep_last = &clr_cnt;
    st.stall      = stall;
  end

endmodule

`default_nettype wire

/* sv/binary_trie_address_allocator_top.sv */
// Top level of the binary trie address allocator: sequencer plus datapath.
// Depends on bta_pkg, bta_if, bta_sequencer and bta_datapath.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+-------------------------------------
//   req      | in  | valid / ready      | op, address
//   rsp      | out | valid / ready      | granted_address, ok, free_count
//   cfg      | in  | cfg_we (no wait)   | cfg_wdata = active_bits
//
// A get walks down one step per tree level, then back up one step per level while parents
// fill. A release clears one level per cycle on its way up. A failed get ends early.
// Reset or a cfg write clears all 2^(MAX_BITS+1) flags, one flag per cycle, then reserves
// address 0; req.ready stays low meanwhile.
// A result waiting on rsp stalls only the next result; a new request is still taken.
`default_nettype none

module binary_trie_address_allocator_top import bta_pkg::*; #(
  parameter int MAX_BITS = DEF_MAX_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  bta_req_if.sink          req,
  bta_rsp_if.source        rsp
);

  act_t    act;
  status_t st;

  bta_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .cfg_we (cfg_we),
    .st     (st),
    .act    (act)
  );

  bta_datapath #(
    .MAX_BITS (MAX_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .act       (act),
    .st        (st),
    .req       (req),
    .rsp       (rsp)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while previous transaction still in progress");

  a_busy_after_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !req.ready)
    else $error("request ready during store clear");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ok) |-> (rsp.granted_address == '0))
    else $error("failed transaction carries a nonzero address");

  a_stall_pending: assert property (@(posedge clk) disable iff (rst)
    st.stall |-> (rsp.valid && !rsp.ready))
    else $error("sequencer stalled with no blocked result");
`endif

endmodule

`default_nettype wire

/* tb/binary_trie_address_allocator_top_tb.sv */
`timescale 1ns / 1ps
// Testbench for binary_trie_address_allocator_top: directed and random get/release traffic
// over several address widths, checked against a flag-tree predictor in a scoreboard class.
// Depends on bta_pkg, bta_req_if / bta_rsp_if and the allocator RTL.

module binary_trie_address_allocator_top_tb;
  import bta_pkg::*;

  localparam int TREE_NODES = 2 ** (DEF_MAX_BITS + 1);
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 2 * DEF_MAX_BITS + 12;

  typedef struct packed {
    logic [DEF_MAX_BITS-1:0] granted;
    logic                    ok;
    logic [DEF_MAX_BITS:0]   free_count;
  } alloc_rsp_t;

  class alloc_tracker;
    bit node_full [TREE_NODES];
    int unsigned free_cnt;
    logic [CFG_W-1:0] width_reg;
    alloc_rsp_t pending [$];
    int errors;

    function new();
      errors = 0;
      set_width(RESET_ACTIVE_BITS);
    endfunction

    function int unsigned eff_bits();
      if (width_reg == 0) return 1;
      if (width_reg > DEF_MAX_BITS) return DEF_MAX_BITS;
      return width_reg;
    endfunction

    // Walk down from the root; hop to the one branch wherever the zero branch is full, never backtrack.
    function bit try_get(int unsigned want, output int unsigned granted);
      int unsigned bits, addr, n, c, sh, b, m;
      bits = eff_bits();
      addr = want & ((1 << bits) - 1);
      n = 1;
      granted = 0;
      if (node_full[1]) return 0;
      for (int lvl = 0; lvl < bits; lvl++) begin
        sh = bits - 1 - lvl;
        b = (addr >> sh) & 1;
        c = (2 * n + b) % TREE_NODES;
        if (node_full[c]) begin
          if (b != 0) return 0;
          c = (2 * n + 1) % TREE_NODES;
          addr = (addr | (1 << sh)) & ~((1 << sh) - 1);
          if (node_full[c]) return 0;
        end
        n = c;
      end
      if (node_full[n]) return 0;
      node_full[n] = 1;
      m = n >> 1;
      while (m != 0) begin
        if (node_full[2 * m] && node_full[2 * m + 1]) node_full[m] = 1;
        m = m >> 1;
      end
      granted = addr;
      return 1;
    endfunction

    function bit try_release(int unsigned addr_in);
      int unsigned bits, n;
      bits = eff_bits();
      n = addr_in & ((1 << bits) - 1);
      if (n == 0) return 0;
      n = n | (1 << bits);
      if (!node_full[n]) return 0;
      while (n != 0) begin
        node_full[n] = 0;
        n = n >> 1;
      end
      return 1;
    endfunction

    // Clear the tree and reserve address zero, as the block does on reset or write.
    function void set_width(logic [CFG_W-1:0] value);
      int unsigned unused_grant;
      width_reg = value;
      foreach (node_full[i]) node_full[i] = 0;
      free_cnt = 1 << eff_bits();
      if (try_get(0, unused_grant)) free_cnt--;
    endfunction

    function alloc_rsp_t note_request(logic op, logic [7:0] addr);
      alloc_rsp_t want_rsp;
      int unsigned grant;
      bit ok;
      grant = 0;
      if (op == OP_GET) begin
        ok = try_get(addr, grant);
        if (ok && free_cnt > 0) free_cnt--;
        if (!ok) grant = 0;
      end else begin
        ok = try_release(addr);
        if (ok) free_cnt++;
      end
      want_rsp.granted = grant[DEF_MAX_BITS-1:0];
      want_rsp.ok = ok;
      want_rsp.free_count = free_cnt[DEF_MAX_BITS:0];
      pending.push_back(want_rsp);
      return want_rsp;
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_response(alloc_rsp_t got);
      alloc_rsp_t want_rsp;
      if (pending.size() == 0) begin
        report($sformatf("unexpected response addr=%0d ok=%0b free=%0d",
                         got.granted, got.ok, got.free_count));
        return;
      end
      want_rsp = pending.pop_front();
      if (got.granted !== want_rsp.granted)
        report($sformatf("granted_address %0d, want %0d", got.granted, want_rsp.granted));
      if (got.ok !== want_rsp.ok)
        report($sformatf("ok %0b, want %0b", got.ok, want_rsp.ok));
      if (got.free_count !== want_rsp.free_count)
        report($sformatf("free_count %0d, want %0d", got.free_count, want_rsp.free_count));
    endtask

    task flag_leftovers();
      if (pending.size() != 0)
        report($sformatf("%0d responses never arrived", pending.size()));
    endtask
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  bta_req_if req_ch ();
  bta_rsp_if rsp_ch ();

  binary_trie_address_allocator_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  alloc_tracker tracker;
  int unsigned held_addrs [$];
  bit send_quiet;
  bit recv_quiet;
  int unsigned cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
      tracker.check_response('{rsp_ch.granted_address, rsp_ch.ok, rsp_ch.free_count});
  end

  // Response side: hold ready low for a random gap (none when recv_quiet is set) before taking each transaction.
  initial begin
    int gap;
    forever begin
      gap = recv_quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (rsp_ch.valid !== 1'b1) @(posedge clk);
    end
  end

  task automatic send_item(logic op, logic [7:0] addr);
    alloc_rsp_t want_rsp;
    int gap;
    int unsigned low_mask;
    gap = send_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op <= op;
    req_ch.address <= addr;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    low_mask = (1 << tracker.eff_bits()) - 1;
    want_rsp = tracker.note_request(op, addr);
    if (want_rsp.ok && op == OP_GET) begin
      held_addrs.push_back(want_rsp.granted);
    end else if (want_rsp.ok) begin
      for (int i = 0; i < held_addrs.size(); i++) begin
        if (held_addrs[i] == (addr & low_mask)) begin
          held_addrs.delete(i);
          break;
        end
      end
    end
  endtask

  // Hold off new requests until every response is back and the tree walk has settled.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(logic [CFG_W-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_width(value);
    held_addrs.delete();
  endtask

  task automatic random_phase(int count);
    int unsigned pick, low_mask, addr;
    int idx;
    for (int k = 0; k < count; k++) begin
      if (k == 0 || k == count / 2) begin
        send_quiet = ($urandom_range(0, 3) == 0);
        recv_quiet = ($urandom_range(0, 3) == 0);
      end
      if (k == count / 2 && $urandom_range(0, 1) == 1) drain();
      low_mask = (1 << tracker.eff_bits()) - 1;
      pick = $urandom_range(0, 99);
      if (pick < 35 && held_addrs.size() > 0) begin
        // free a held address, with junk in the bits above the active width
        idx = $urandom_range(0, held_addrs.size() - 1);
        addr = held_addrs[idx] | ($urandom_range(0, 255) & ~low_mask);
        send_item(OP_REL, addr[7:0]);
      end else if (pick < 47) begin
        send_item(OP_REL, 8'($urandom_range(0, 255)));
      end else if (pick < 55) begin
        send_item(OP_GET, 8'($urandom_range(0, 3)));
      end else begin
        send_item(OP_GET, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    tracker = new();
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= RESET_ACTIVE_BITS;
    req_ch.valid <= 1'b0;
    req_ch.op <= OP_GET;
    req_ch.address <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero reserved, hop to the one branch, failed gets, ignored releases.
    send_item(OP_GET, 8'h00);
    send_item(OP_GET, 8'h00);
    send_item(OP_GET, 8'hFF);
    send_item(OP_GET, 8'hFF);
    send_item(OP_GET, 8'h80);
    send_item(OP_GET, 8'h7F);
    send_item(OP_GET, 8'hAA);
    send_item(OP_GET, 8'h55);
    send_item(OP_REL, 8'h00);
    send_item(OP_REL, 8'hFF);
    send_item(OP_REL, 8'hFF);
    send_item(OP_REL, 8'h01);
    send_item(OP_GET, 8'h01);
    send_item(OP_REL, 8'h80);
    send_item(OP_GET, 8'h80);
    send_item(OP_REL, 8'h7F);
    send_item(OP_REL, 8'hAA);
    send_item(OP_REL, 8'h55);
    send_item(OP_REL, 8'h80);
    send_item(OP_REL, 8'h01);
    send_item(OP_REL, 8'h33);

    write_width(4'd3);
    random_phase(50);
    write_width(4'd1);
    random_phase(25);
    write_width(4'd0);
    random_phase(25);
    write_width(4'd15);
    random_phase(60);
    write_width(4'd2);
    random_phase(30);
    write_width(4'd4);
    random_phase(50);
    write_width(4'd9);
    random_phase(50);
    write_width(4'd5);
    random_phase(50);
    write_width(4'd7);
    random_phase(50);
    write_width(4'd6);
    random_phase(50);
    write_width(4'd8);
    random_phase(90);

    drain();
    tracker.flag_leftovers();
    if (tracker.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
